[design/dnve_pkg.sv]
// ----------------------------------------------------------------------------
// dnve_pkg
// Shared types, character codes and helpers of the DN value escaper.
// ----------------------------------------------------------------------------
package dnve_pkg;

   localparam int unsigned CharWidth = 21;

   typedef logic [CharWidth-1:0] char_type;

   localparam char_type CH_SPACE     = 21'h000020;
   localparam char_type CH_QUOTE     = 21'h000022;
   localparam char_type CH_BACKSLASH = 21'h00005C;
   localparam char_type CH_COMMA     = 21'h00002C;
   localparam char_type CH_PLUS      = 21'h00002B;
   localparam char_type CH_LESS      = 21'h00003C;
   localparam char_type CH_GREATER   = 21'h00003E;
   localparam char_type CH_SEMICOLON = 21'h00003B;
   localparam char_type CH_HASH      = 21'h000023;
   localparam char_type CH_EQUALS    = 21'h00003D;

   // One escaped input character: optional backslash, then the character.
   typedef struct packed {
      logic     valid;
      logic     bs;
      char_type ch;
   } emit_type;

   // All results caused by one input transfer.
   typedef struct packed {
      emit_type e0;
      emit_type e1;
      logic     fin;
      logic     quote;
      logic     dspace;
   } grp_type;

   function automatic logic is_quote(input char_type ch);
      return (ch == CH_QUOTE) || (ch == CH_BACKSLASH);
   endfunction

   function automatic logic needs_bs(input char_type ch);
      return (ch == CH_QUOTE) || (ch == CH_BACKSLASH) || (ch == CH_COMMA) ||
             (ch == CH_PLUS) || (ch == CH_LESS) || (ch == CH_GREATER) ||
             (ch == CH_SEMICOLON) || (ch == CH_HASH) || (ch == CH_EQUALS);
   endfunction

endpackage

[design/dnve_if.sv]
// ----------------------------------------------------------------------------
// dnve_req_if / dnve_rsp_if
// Valid/ready channels for input characters and escaped results.
// ----------------------------------------------------------------------------
interface dnve_req_if;
   logic                valid;
   logic                ready;
   dnve_pkg::char_type  in_char;
   logic                is_final;
   logic                quote_seed;

   modport source (output valid, in_char, is_final, quote_seed, input ready);
   modport sink   (input valid, in_char, is_final, quote_seed, output ready);
endinterface

interface dnve_rsp_if;
   logic                valid;
   logic                ready;
   dnve_pkg::char_type  out_char;
   logic                run_end;
   logic                string_end;
   logic                quote_seen;
   logic                double_space;

   modport source (output valid, out_char, run_end, string_end, quote_seen,
                   double_space, input ready);
   modport sink   (input valid, out_char, run_end, string_end, quote_seen,
                   double_space, output ready);
endinterface

[design/dnve_core.sv]
// ----------------------------------------------------------------------------
// dnve_core
// Held-character state and escape decision for one input transfer.
// ----------------------------------------------------------------------------
module dnve_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  dnve_pkg::char_type in_char,
   input  logic               is_final,
   input  logic               quote_seed,
   output logic               has_results,
   output dnve_pkg::grp_type  grp
);

   dnve_pkg::char_type held_char_ff, held_char_in;
   logic held_valid_ff, held_valid_in;
   logic held_first_ff, held_first_in;
   logic escape_run_ff, escape_run_in;
   logic quote_flag_ff, quote_flag_in;
   logic space_pair_ff, space_pair_in;

   logic held_sp, next_sp, er1, spf1, q1, q2;

   always_comb begin
      held_char_in  = held_char_ff;
      held_valid_in = held_valid_ff;
      held_first_in = held_first_ff;
      escape_run_in = escape_run_ff;
      quote_flag_in = quote_flag_ff;
      space_pair_in = space_pair_ff;
      has_results   = 1'b0;
      grp           = '0;
      held_sp       = (held_char_ff == dnve_pkg::CH_SPACE);
      next_sp       = (in_char == dnve_pkg::CH_SPACE);
      er1           = held_sp & (escape_run_ff | next_sp | held_first_ff);
      spf1          = space_pair_ff | (held_sp & next_sp);
      q1            = quote_flag_ff | dnve_pkg::is_quote(held_char_ff);
      q2            = q1 | dnve_pkg::is_quote(in_char);
      if (!held_valid_ff) begin
         escape_run_in = 1'b0;
         space_pair_in = 1'b0;
         quote_flag_in = quote_seed;
         if (is_final) begin
            has_results    = 1'b1;
            grp.e0.valid   = 1'b1;
            grp.e0.bs      = next_sp | dnve_pkg::needs_bs(in_char);
            grp.e0.ch      = in_char;
            grp.fin        = 1'b1;
            grp.quote      = quote_seed | dnve_pkg::is_quote(in_char);
            grp.dspace     = 1'b0;
            quote_flag_in  = grp.quote;
            held_char_in   = '0;
            held_first_in  = 1'b0;
         end else begin
            held_char_in  = in_char;
            held_valid_in = 1'b1;
            held_first_in = 1'b1;
         end
      end else begin
         has_results  = 1'b1;
         grp.e0.valid = 1'b1;
         grp.e0.bs    = held_sp ? er1 : dnve_pkg::needs_bs(held_char_ff);
         grp.e0.ch    = held_char_ff;
         space_pair_in = spf1;
         if (is_final) begin
            grp.e1.valid  = 1'b1;
            grp.e1.bs     = next_sp | dnve_pkg::needs_bs(in_char);
            grp.e1.ch     = in_char;
            grp.fin       = 1'b1;
            grp.quote     = q2;
            grp.dspace    = spf1;
            quote_flag_in = q2;
            held_char_in  = '0;
            held_valid_in = 1'b0;
            held_first_in = 1'b0;
            escape_run_in = 1'b0;
         end else begin
            quote_flag_in = q1;
            held_char_in  = in_char;
            held_first_in = 1'b0;
            escape_run_in = er1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_char_ff  <= '0;
         held_valid_ff <= 1'b0;
         held_first_ff <= 1'b0;
         escape_run_ff <= 1'b0;
         quote_flag_ff <= 1'b0;
         space_pair_ff <= 1'b0;
      end else if (accept) begin
         held_char_ff  <= held_char_in;
         held_valid_ff <= held_valid_in;
         held_first_ff <= held_first_in;
         escape_run_ff <= escape_run_in;
         quote_flag_ff <= quote_flag_in;
         space_pair_ff <= space_pair_in;
      end
   end

endmodule

[design/dnve_serializer.sv]
// ----------------------------------------------------------------------------
// dnve_serializer
// Result register that drains one result group, one character per transfer.
// ----------------------------------------------------------------------------
module dnve_serializer (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  dnve_pkg::grp_type grp_in,
   output logic              free,
   dnve_rsp_if.source        rsp_if
);

   localparam logic [1:0] POS_E0_BS = 2'd0;
   localparam logic [1:0] POS_E0_CH = 2'd1;
   localparam logic [1:0] POS_E1_BS = 2'd2;
   localparam logic [1:0] POS_E1_CH = 2'd3;

   dnve_pkg::grp_type grp_ff;
   logic              busy_ff, busy_in;
   logic [1:0]        pos_ff, pos_in, load_pos;
   logic              last, take;

   assign take = busy_ff & rsp_if.ready;
   assign free = ~busy_ff | (take & last);

   always_comb begin
      last = 1'b0;
      unique case (pos_ff)
         POS_E0_BS: last = 1'b0;
         POS_E0_CH: last = ~grp_ff.e1.valid;
         POS_E1_BS: last = 1'b0;
         POS_E1_CH: last = 1'b1;
         default:   last = 1'b1;
      endcase
   end

   always_comb begin
      if (grp_in.e0.valid) begin
         load_pos = grp_in.e0.bs ? POS_E0_BS : POS_E0_CH;
      end else begin
         load_pos = grp_in.e1.bs ? POS_E1_BS : POS_E1_CH;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      pos_in  = pos_ff;
      if (take) begin
         if (last) begin
            busy_in = 1'b0;
         end else if (pos_ff == POS_E0_CH) begin
            pos_in = grp_ff.e1.bs ? POS_E1_BS : POS_E1_CH;
         end else begin
            pos_in = pos_ff + 2'd1;
         end
      end
      if (load) begin
         busy_in = 1'b1;
         pos_in  = load_pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pos_ff  <= POS_E0_BS;
      end else begin
         busy_ff <= busy_in;
         pos_ff  <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         grp_ff <= grp_in;
      end
   end

   always_comb begin
      unique case (pos_ff)
         POS_E0_BS: rsp_if.out_char = dnve_pkg::CH_BACKSLASH;
         POS_E0_CH: rsp_if.out_char = grp_ff.e0.ch;
         POS_E1_BS: rsp_if.out_char = dnve_pkg::CH_BACKSLASH;
         POS_E1_CH: rsp_if.out_char = grp_ff.e1.ch;
         default:   rsp_if.out_char = grp_ff.e1.ch;
      endcase
   end

   assign rsp_if.valid        = busy_ff;
   assign rsp_if.run_end      = last;
   assign rsp_if.string_end   = last & grp_ff.fin;
   assign rsp_if.quote_seen   = last & grp_ff.fin & grp_ff.quote;
   assign rsp_if.double_space = last & grp_ff.fin & grp_ff.dspace;

endmodule

[design/dn_value_escaper.sv]
// ----------------------------------------------------------------------------
// dn_value_escaper
// Streaming escaper for directory-name attribute values.
// ----------------------------------------------------------------------------
// Characters arrive one per transfer with an end-of-string mark; the block
// holds one character back, decides its escape from the character after it,
// and emits one to four result characters per input through a result register
// that drains one character per cycle while the receiver is ready. A new input
// is taken in the cycle the last result of the previous input transfers, so the
// block takes no new input while it still holds results of the previous one;
// the first character of a multi-character string produces no result.
// ----------------------------------------------------------------------------
module dn_value_escaper (
   input  logic       clock,
   input  logic       reset,
   dnve_req_if.sink   req_if,
   dnve_rsp_if.source rsp_if
);

   logic              accept;
   logic              free;
   logic              has_results;
   dnve_pkg::grp_type grp;

   assign req_if.ready = free;
   assign accept       = req_if.valid & free;

   dnve_core u_core (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .in_char     (req_if.in_char),
      .is_final    (req_if.is_final),
      .quote_seed  (req_if.quote_seed),
      .has_results (has_results),
      .grp         (grp)
   );

   dnve_serializer u_serializer (
      .clock  (clock),
      .reset  (reset),
      .load   (accept & has_results),
      .grp_in (grp),
      .free   (free),
      .rsp_if (rsp_if)
   );

endmodule
